/* rtl/spfu_pkg.sv */
`default_nettype none

package spfu_pkg;

   // operation codes carried in req_tuser
   typedef enum logic [2:0] {
      OP_CPU_WRITE   = 3'd0,
      OP_CPU_READ    = 3'd1,
      OP_HOST_PUSH   = 3'd2,
      OP_HOST_POP    = 3'd3,
      OP_TIME_UPDATE = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FINISH
   } state_type;

   // source of read_data for the current item
   typedef enum logic [1:0] {
      RD_NONE,
      RD_STATUS,
      RD_POP,
      RD_OPEN
   } rd_kind_type;

   localparam int OP_W    = 3;
   localparam int NOW_W   = 31;
   localparam int ADDR_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int CPB_W   = 20;
   localparam int TIME_W  = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 20;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_CYCLES_PER_BYTE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_MASK    = 1'b1;

   localparam logic [CPB_W-1:0]  CPB_RESET  = 20'd1000;
   localparam logic [ADDR_W-1:0] MASK_RESET = 16'd1;

   typedef struct packed {
      logic load;    // latch the accepted item
      logic exec;    // act on fifos, pointers and pacing times
      logic finish;  // recompute interrupt, fill result register
   } cmd_type;

   typedef struct packed {
      logic out_free;  // result register can take a new item
   } status_type;

endpackage

`default_nettype wire

/* rtl/serial_port_with_paced_fifos_unit.sv */
// An accepted item passes through the fifo/pointer update (exec), then the result step
// (finish), which registers rsp_tvalid. A new item is taken only while idle: req_tready
// is low during the fifo/pointer update and the result step that follow each accept.
// Stall: a result not yet taken on rsp holds the next item in its result step.
// Reset (synchronous, active high): pointers, pacing times, irq enables and irq
// cleared; cycles_per_byte = 1000, control_mask = 1; fifo contents unknown.
`default_nettype none

module serial_port_with_paced_fifos_unit #(
   parameter int FIFO_DEPTH = 256
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // item in
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // [30:0] now, [46:31] port_address, [54:47] data_byte, [55] zero
   input  wire [spfu_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [2:0] operation
   input  wire [spfu_pkg::OP_W-1:0]            req_tuser,
   // result out
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // [7:0] read_data, [8] interrupt_request, [9] access_effect,
   // [17:10] host_data, [18] host_valid, [19] push_dropped, [23:20] zero
   output logic [spfu_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // register writes: 0 cycles_per_byte, 1 control_mask
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [spfu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [spfu_pkg::CSR_DATA_W-1:0]      csr_data
);

   spfu_pkg::cmd_type    cmd;
   spfu_pkg::status_type status;

   // sequencer: idle -> exec -> finish, finish waits for a free result slot
   spfu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // fifos, pointers, pacing times, interrupt and result register
   spfu_dpath #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_operation    (req_tuser),
      .in_now          (req_tdata[30:0]),
      .in_port_address (req_tdata[46:31]),
      .in_data_byte    (req_tdata[54:47]),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata)
   );

endmodule

`default_nettype wire

/* rtl/spfu_ctrl.sv */
`default_nettype none

module spfu_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire spfu_pkg::status_type status,
   output spfu_pkg::cmd_type     cmd
);

   spfu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spfu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         spfu_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = spfu_pkg::ST_EXEC;
            end
         end
         spfu_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = spfu_pkg::ST_FINISH;
         end
         spfu_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = spfu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spfu_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/spfu_dpath.sv */
`default_nettype none

module spfu_dpath #(
   parameter int FIFO_DEPTH = 256
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire spfu_pkg::cmd_type                 cmd,
   output spfu_pkg::status_type                   status,
   input  wire [spfu_pkg::OP_W-1:0]               in_operation,
   input  wire [spfu_pkg::NOW_W-1:0]              in_now,
   input  wire [spfu_pkg::ADDR_W-1:0]             in_port_address,
   input  wire [spfu_pkg::BYTE_W-1:0]             in_data_byte,
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire [spfu_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire [spfu_pkg::CSR_DATA_W-1:0]         csr_data,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [spfu_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   localparam int IW = $clog2(FIFO_DEPTH);
   localparam int PW = IW + 1;
   localparam logic [PW:0]   PTR_MOD  = (PW+1)'(2 * FIFO_DEPTH);
   localparam logic [PW:0]   DEPTH_W  = (PW+1)'(FIFO_DEPTH);
   localparam logic [PW-1:0] PTR_LAST = PW'(2 * FIFO_DEPTH - 1);
   localparam logic [PW-1:0] PTR_HALF = PW'(FIFO_DEPTH);
   localparam int BW = spfu_pkg::BYTE_W;
   localparam int TW = spfu_pkg::TIME_W;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PW:0] fill_count(input logic [PW-1:0] wp,
                                              input logic [PW-1:0] rp);
      logic [PW:0] base;
      base = {1'b0, wp} + ((wp < rp) ? PTR_MOD : '0);
      return base - {1'b0, rp};
   endfunction

   function automatic logic [IW-1:0] ptr_index(input logic [PW-1:0] p);
      logic [PW-1:0] q;
      q = (p >= PTR_HALF) ? p - PTR_HALF : p;
      return q[IW-1:0];
   endfunction

   // configuration
   logic [spfu_pkg::CPB_W-1:0]  cpb_ff;
   logic [spfu_pkg::ADDR_W-1:0] mask_ff;

   // latched item
   logic [spfu_pkg::OP_W-1:0]   op_ff;
   logic [spfu_pkg::NOW_W-1:0]  now_ff;
   logic [spfu_pkg::ADDR_W-1:0] addr_ff;
   logic [BW-1:0]               byte_ff;

   // port state
   logic [PW-1:0] tx_wp_ff, tx_rp_ff, rx_wp_ff, rx_rp_ff;
   logic [TW-1:0] tx_time_ff, rx_time_ff;
   logic          tx_en_ff, rx_en_ff, irq_ff;

   logic [BW-1:0] tx_mem [FIFO_DEPTH];
   logic [BW-1:0] rx_mem [FIFO_DEPTH];
   logic [BW-1:0] tx_rd_ff, rx_rd_ff;

   // decisions carried from exec to finish
   spfu_pkg::rd_kind_type rd_kind_ff, rd_kind_in;
   logic [BW-1:0] status_mask_ff;
   logic [BW-1:0] open_ptr_ff;
   logic          effect_ff, ctrl_wr_ff, hvalid_ff, dropped_ff;
   logic          effect_in, ctrl_wr_in, hvalid_in, dropped_in;

   // result register
   logic                            rsp_valid_ff;
   logic [spfu_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [TW-1:0] now_ext;
   logic [PW:0]   tx_fill, rx_fill;
   logic          tx_rdy, rx_rdy, is_ctrl;
   logic [TW-1:0] tx_sum, rx_sum, tx_paced, rx_paced;
   logic          tx_wr, rx_wr, tx_pop, rx_pop;
   logic          irq_new;
   logic [BW-1:0] rd_value, hdata;

   assign csr_ready       = 1'b1;
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cpb_ff  <= spfu_pkg::CPB_RESET;
         mask_ff <= spfu_pkg::MASK_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            spfu_pkg::CSR_CYCLES_PER_BYTE: cpb_ff  <= csr_data;
            spfu_pkg::CSR_CONTROL_MASK:    mask_ff <= csr_data[spfu_pkg::ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= in_operation;
         now_ff  <= in_now;
         addr_ff <= in_port_address;
         byte_ff <= in_data_byte;
      end
   end

   // readiness from current state and the item's cycle count
   assign now_ext = {1'b0, now_ff};
   assign tx_fill = fill_count(tx_wp_ff, tx_rp_ff);
   assign rx_fill = fill_count(rx_wp_ff, rx_rp_ff);
   assign tx_rdy  = (tx_fill < DEPTH_W) && (now_ext >= tx_time_ff);
   assign rx_rdy  = (rx_fill != '0) && (now_ext >= rx_time_ff);
   assign is_ctrl = (addr_ff & mask_ff) != '0;

   assign tx_sum   = tx_time_ff + TW'(cpb_ff);
   assign rx_sum   = rx_time_ff + TW'(cpb_ff);
   assign tx_paced = (tx_sum > now_ext) ? tx_sum : now_ext;
   assign rx_paced = (rx_sum > now_ext) ? rx_sum : now_ext;

   always_comb begin
      tx_wr      = 1'b0;
      rx_wr      = 1'b0;
      tx_pop     = 1'b0;
      rx_pop     = 1'b0;
      rd_kind_in = spfu_pkg::RD_NONE;
      effect_in  = 1'b0;
      ctrl_wr_in = 1'b0;
      hvalid_in  = 1'b0;
      dropped_in = 1'b0;
      case (op_ff)
         spfu_pkg::OP_CPU_WRITE: begin
            if (is_ctrl) begin
               ctrl_wr_in = 1'b1;
            end else if (tx_rdy) begin
               tx_wr     = 1'b1;
               effect_in = 1'b1;
            end
         end
         spfu_pkg::OP_CPU_READ: begin
            if (is_ctrl) begin
               rd_kind_in = spfu_pkg::RD_STATUS;
            end else if (rx_rdy) begin
               rx_pop     = 1'b1;
               effect_in  = 1'b1;
               rd_kind_in = spfu_pkg::RD_POP;
            end else begin
               rd_kind_in = spfu_pkg::RD_OPEN;
            end
         end
         spfu_pkg::OP_HOST_PUSH: begin
            if (rx_fill < DEPTH_W) begin
               rx_wr = 1'b1;
            end else begin
               dropped_in = 1'b1;
            end
         end
         spfu_pkg::OP_HOST_POP: begin
            if (tx_fill != '0) begin
               tx_pop    = 1'b1;
               hvalid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // fifo storage: one write and one registered read per array; the read is
   // taken in exec so a stalled result keeps the popped byte
   always_ff @(posedge clock) begin
      if (cmd.exec && tx_wr) begin
         tx_mem[ptr_index(tx_wp_ff)] <= byte_ff;
      end
      if (cmd.exec) begin
         tx_rd_ff <= tx_mem[ptr_index(tx_rp_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && rx_wr) begin
         rx_mem[ptr_index(rx_wp_ff)] <= byte_ff;
      end
      if (cmd.exec) begin
         rx_rd_ff <= rx_mem[ptr_index(rx_rp_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rd_kind_ff     <= rd_kind_in;
         effect_ff      <= effect_in;
         ctrl_wr_ff     <= ctrl_wr_in;
         hvalid_ff      <= hvalid_in;
         dropped_ff     <= dropped_in;
         status_mask_ff <= {{(BW-2){1'b1}}, rx_rdy, tx_rdy};
         open_ptr_ff    <= BW'(tx_rp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_wp_ff   <= '0;
         tx_rp_ff   <= '0;
         rx_wp_ff   <= '0;
         rx_rp_ff   <= '0;
         tx_time_ff <= '0;
         rx_time_ff <= '0;
         tx_en_ff   <= 1'b0;
         rx_en_ff   <= 1'b0;
      end else if (cmd.exec) begin
         if (ctrl_wr_in) begin
            tx_en_ff <= byte_ff[0];
            rx_en_ff <= byte_ff[1];
         end
         if (tx_wr) begin
            tx_wp_ff   <= ptr_next(tx_wp_ff);
            tx_time_ff <= tx_paced;
         end
         if (rx_pop) begin
            rx_rp_ff   <= ptr_next(rx_rp_ff);
            rx_time_ff <= rx_paced;
         end
         if (rx_wr) begin
            rx_wp_ff <= ptr_next(rx_wp_ff);
         end
         if (tx_pop) begin
            tx_rp_ff <= ptr_next(tx_rp_ff);
         end
      end
   end

   // finish: state is updated, readiness is seen again
   assign irq_new = (rx_rdy && rx_en_ff) || (tx_rdy && tx_en_ff);

   always_comb begin
      case (rd_kind_ff)
         spfu_pkg::RD_STATUS: rd_value = byte_ff & status_mask_ff;
         spfu_pkg::RD_POP:    rd_value = byte_ff & rx_rd_ff;
         spfu_pkg::RD_OPEN:   rd_value = byte_ff & open_ptr_ff;
         default:             rd_value = '0;
      endcase
   end

   assign hdata = hvalid_ff ? tx_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            irq_ff       <= irq_new;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= {4'b0, dropped_ff, hvalid_ff, hdata,
                         effect_ff || (ctrl_wr_ff && (irq_ff != irq_new)),
                         irq_new, rd_value};
      end
   end

endmodule

`default_nettype wire
